// ----- hdl/sfmu_pkg.sv -----
// Shared types, constants and helper functions of the spectral forcing mode update block.
// Used by spectral_forcing_mode_update and sfmu_proj; depends on nothing else.

package sfmu_pkg;

	// Field and storage widths.
	localparam int SLOT_W     = 10;
	localparam int MODE_SLOTS = 1024;
	localparam int WAVE_W     = 6;
	localparam int MAX_WAVE   = 16;
	localparam int SAMPLE_W   = 24;
	localparam int COEF_W     = 17;
	localparam int NDIM       = 3;
	localparam int NLANE      = 2 * NDIM;

	// Projection datapath widths.
	localparam int K2_W   = 10;
	localparam int KA_W   = WAVE_W + SAMPLE_W;
	localparam int DOT_W  = KA_W + 2;
	localparam int KW_W   = WAVE_W + 19;
	localparam int Q_W    = 26;
	localparam int P_W    = Q_W + 1;
	localparam int DVD_W  = 35;
	localparam int LANE_LAT = 3 + Q_W;

	// Blend widths.
	localparam int MX_W  = COEF_W + 1 + SAMPLE_W;
	localparam int MY_W  = COEF_W + 1 + P_W;
	localparam int SUM_W = MY_W + 1;
	localparam int SH_W  = SUM_W - 16;

	// Configuration register indexes.
	localparam int REG_IDX_W = 3;
	localparam logic [REG_IDX_W-1:0] REG_DRIFT_X   = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_DRIFT_Y   = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_DRIFT_Z   = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_DIFF_X    = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_DIFF_Y    = 3'd4;
	localparam logic [REG_IDX_W-1:0] REG_DIFF_Z    = 3'd5;
	localparam logic [REG_IDX_W-1:0] REG_WEIGHT    = 3'd6;
	localparam logic [REG_IDX_W-1:0] REG_DECAY     = 3'd7;

	localparam logic [COEF_W-1:0] ONE_Q16 = 17'h10000;

	// Side information that travels beside the projection lanes.
	typedef struct packed {
		logic              valid;
		logic              zero;
		logic [SLOT_W-1:0] slot;
	} sb_t;

	// Coefficients above 1.0 act as 1.0.
	function automatic logic [COEF_W-1:0] coef_eff(input logic [COEF_W-1:0] r);
		coef_eff = r[COEF_W-1] ? ONE_Q16 : r;
	endfunction

	// Wave numbers are limited to plus or minus MAX_WAVE.
	function automatic logic signed [WAVE_W-1:0] clamp_wave(input logic signed [WAVE_W-1:0] v);
		if (v > WAVE_W'(MAX_WAVE))
			clamp_wave = WAVE_W'(MAX_WAVE);
		else if (v < -WAVE_W'(MAX_WAVE))
			clamp_wave = -WAVE_W'(MAX_WAVE);
		else
			clamp_wave = v;
	endfunction

	// Saturate a rounded blend to the sample range.
	function automatic logic [SAMPLE_W-1:0] sat_sample(input logic signed [SH_W-1:0] v);
		logic signed [SH_W-1:0] hi;
		logic signed [SH_W-1:0] lo;
		hi = SH_W'({1'b0, {(SAMPLE_W-1){1'b1}}});
		lo = -hi - SH_W'(1);
		if (v > hi)
			sat_sample = {1'b0, {(SAMPLE_W-1){1'b1}}};
		else if (v < lo)
			sat_sample = {1'b1, {(SAMPLE_W-1){1'b0}}};
		else
			sat_sample = v[SAMPLE_W-1:0];
	endfunction

endpackage

// ----- hdl/spectral_forcing_mode_update.sv -----
// Spectral forcing mode update: Helmholtz projection and OU step per stored mode.
// One item per cycle, unless the clearing pass, a same-slot hazard or output back-pressure stalls the flow.
// Two items in a row on the same slot cost a bubble at the memory read-modify-write.
// After reset a clearing pass writes zeros to all 1024 slots, with s_axis_tready low.
// Configuration registers reset to drift 1.0, diffusion 0, weight 1.0, decay off.
// Depends on sfmu_pkg, sfmu_ram, sfmu_div and sfmu_proj.

module spectral_forcing_mode_update import sfmu_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         psel,
	input  logic         penable,
	input  logic         pwrite,
	input  logic [4:0]   paddr,
	input  logic [31:0]  pwdata,
	output logic [31:0]  prdata,
	output logic         pready,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	// slot, wave_x, wave_y, wave_z, inj_even_x/y/z, inj_odd_x/y/z, zero padding
	input  logic [175:0] s_axis_tdata,
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// out_slot, spec_even_x/y/z, spec_odd_x/y/z, zero padding
	output logic [159:0] m_axis_tdata,
	// zero_wave
	output logic [0:0]   m_axis_tuser
);

	localparam int RAM_W = NLANE * SAMPLE_W;

	// Configuration registers.
	logic [COEF_W-1:0] drift_q [NDIM];
	logic [COEF_W-1:0] diff_q  [NDIM];
	logic [COEF_W-1:0] weight_q;
	logic              decay_q;
	logic [REG_IDX_W-1:0] reg_idx;
	logic              cfg_wr;

	assign pready  = 1'b1;
	assign reg_idx = paddr[4:2];
	assign cfg_wr  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int c = 0; c < NDIM; c++) begin
				drift_q[c] <= ONE_Q16;
				diff_q[c]  <= '0;
			end
			weight_q <= ONE_Q16;
			decay_q  <= 1'b0;
		end else if (cfg_wr) begin
			unique case (reg_idx)
				REG_DRIFT_X: drift_q[0] <= pwdata[COEF_W-1:0];
				REG_DRIFT_Y: drift_q[1] <= pwdata[COEF_W-1:0];
				REG_DRIFT_Z: drift_q[2] <= pwdata[COEF_W-1:0];
				REG_DIFF_X:  diff_q[0]  <= pwdata[COEF_W-1:0];
				REG_DIFF_Y:  diff_q[1]  <= pwdata[COEF_W-1:0];
				REG_DIFF_Z:  diff_q[2]  <= pwdata[COEF_W-1:0];
				REG_WEIGHT:  weight_q   <= pwdata[COEF_W-1:0];
				REG_DECAY:   decay_q    <= pwdata[0];
				default: ;
			endcase
		end
	end

	// Register read-back.
	always_comb begin
		unique case (reg_idx)
			REG_DRIFT_X: prdata = 32'(drift_q[0]);
			REG_DRIFT_Y: prdata = 32'(drift_q[1]);
			REG_DRIFT_Z: prdata = 32'(drift_q[2]);
			REG_DIFF_X:  prdata = 32'(diff_q[0]);
			REG_DIFF_Y:  prdata = 32'(diff_q[1]);
			REG_DIFF_Z:  prdata = 32'(diff_q[2]);
			REG_WEIGHT:  prdata = 32'(weight_q);
			REG_DECAY:   prdata = 32'(decay_q);
			default:     prdata = '0;
		endcase
	end

	// Effective coefficients.
	logic [COEF_W-1:0] w_eff;
	logic [COEF_W-1:0] drift_eff [NDIM];
	logic [COEF_W-1:0] diff_use  [NDIM];
	logic signed [18:0] wmul;

	always_comb begin
		w_eff = coef_eff(weight_q);
		wmul  = 19'sd65536 - $signed({1'b0, w_eff, 1'b0});
		for (int c = 0; c < NDIM; c++) begin
			drift_eff[c] = coef_eff(drift_q[c]);
			diff_use[c]  = decay_q ? '0 : coef_eff(diff_q[c]);
		end
	end

	// Clearing pass after reset.
	logic [SLOT_W:0] clr_cnt_q;
	logic            clr_done;

	assign clr_done = clr_cnt_q[SLOT_W];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			clr_cnt_q <= '0;
		else if (!clr_done)
			clr_cnt_q <= clr_cnt_q + 1'b1;
	end

	// Pipeline flow control.
	logic adv_tail;
	logic adv_up;
	logic hazard;
	logic d_valid_q;
	logic b_valid_q;
	logic c_valid_q;
	logic [SLOT_W-1:0] b_slot_q;
	sb_t  sb_q [LANE_LAT];

	assign adv_tail      = !d_valid_q || m_axis_tready;
	assign hazard        = sb_q[LANE_LAT-1].valid && b_valid_q &&
	                       (sb_q[LANE_LAT-1].slot == b_slot_q);
	assign adv_up        = adv_tail && !hazard;
	assign s_axis_tready = adv_up && clr_done;

	// Stage 1: unpack and clamp the input transaction.
	logic                       v_s1;
	logic [SLOT_W-1:0]          slot_s1;
	logic signed [WAVE_W-1:0]   k_s1 [NDIM];
	logic signed [SAMPLE_W-1:0] a_s1 [NLANE];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s1 <= 1'b0;
		else if (adv_up)
			v_s1 <= s_axis_tvalid && clr_done;
	end

	always_ff @(posedge clk) begin
		if (adv_up) begin
			slot_s1 <= s_axis_tdata[SLOT_W-1:0];
			for (int c = 0; c < NDIM; c++)
				k_s1[c] <= clamp_wave(s_axis_tdata[SLOT_W + WAVE_W*c +: WAVE_W]);
			for (int i = 0; i < NLANE; i++)
				a_s1[i] <= s_axis_tdata[SLOT_W + WAVE_W*NDIM + SAMPLE_W*i +: SAMPLE_W];
		end
	end

	// Stage 2: lane products k*a, |k|^2 and k*(1-2w).
	logic                       v_s2;
	logic                       zero_s2;
	logic [SLOT_W-1:0]          slot_s2;
	logic signed [KA_W-1:0]     ka_s2 [NLANE];
	logic [K2_W-1:0]            k2_s2;
	logic signed [KW_W-1:0]     kw_s2 [NDIM];
	logic signed [SAMPLE_W-1:0] a_s2 [NLANE];
	logic [K2_W-1:0]            k2_nx;
	logic signed [2*WAVE_W-1:0] ksq [NDIM];

	always_comb begin
		k2_nx = '0;
		for (int c = 0; c < NDIM; c++) begin
			ksq[c] = k_s1[c] * k_s1[c];
			k2_nx  = k2_nx + K2_W'($unsigned(ksq[c]));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s2 <= 1'b0;
		else if (adv_up)
			v_s2 <= v_s1;
	end

	always_ff @(posedge clk) begin
		if (adv_up) begin
			zero_s2 <= (k_s1[0] == '0) && (k_s1[1] == '0) && (k_s1[2] == '0);
			slot_s2 <= slot_s1;
			k2_s2   <= k2_nx;
			for (int c = 0; c < NDIM; c++)
				kw_s2[c] <= k_s1[c] * wmul;
			for (int i = 0; i < NLANE; i++) begin
				ka_s2[i] <= k_s1[i % NDIM] * a_s1[i];
				a_s2[i]  <= a_s1[i];
			end
		end
	end

	// Stage 3: merge the lane products into one dot product per part.
	logic                       v_s3;
	logic                       zero_s3;
	logic [SLOT_W-1:0]          slot_s3;
	logic signed [DOT_W-1:0]    dot_s3 [2];
	logic [K2_W-1:0]            k2_s3;
	logic signed [KW_W-1:0]     kw_s3 [NDIM];
	logic signed [SAMPLE_W-1:0] a_s3 [NLANE];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s3 <= 1'b0;
		else if (adv_up)
			v_s3 <= v_s2;
	end

	always_ff @(posedge clk) begin
		if (adv_up) begin
			zero_s3 <= zero_s2;
			slot_s3 <= slot_s2;
			k2_s3   <= k2_s2;
			for (int part = 0; part < 2; part++)
				dot_s3[part] <= DOT_W'(ka_s2[part*NDIM]) + DOT_W'(ka_s2[part*NDIM+1])
				              + DOT_W'(ka_s2[part*NDIM+2]);
			for (int c = 0; c < NDIM; c++)
				kw_s3[c] <= kw_s2[c];
			for (int i = 0; i < NLANE; i++)
				a_s3[i] <= a_s2[i];
		end
	end

	// Projection lanes, one per spectrum component.
	logic signed [P_W-1:0] p_a [NLANE];

	for (genvar i = 0; i < NLANE; i++) begin : g_lane
		sfmu_proj u_proj (
			.clk(clk),
			.en (adv_up),
			.a  (a_s3[i]),
			.w  (w_eff),
			.k2 (k2_s3),
			.kw (kw_s3[i % NDIM]),
			.dot(dot_s3[i / NDIM]),
			.p  (p_a[i])
		);
	end

	// Side information delay line matching the lane latency.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < LANE_LAT; i++)
				sb_q[i] <= '0;
		end else if (adv_up) begin
			sb_q[0].valid <= v_s3;
			sb_q[0].zero  <= zero_s3;
			sb_q[0].slot  <= slot_s3;
			for (int i = 1; i < LANE_LAT; i++)
				sb_q[i] <= sb_q[i-1];
		end
	end

	// Spectrum memory, all six components of a slot in one word.
	logic              ram_we;
	logic [SLOT_W-1:0] ram_waddr;
	logic [RAM_W-1:0]  ram_wdata;
	logic [RAM_W-1:0]  ram_rdata;
	logic [RAM_W-1:0]  res_c;
	logic [SLOT_W-1:0] c_slot_q;

	assign ram_we    = !clr_done || (c_valid_q && adv_tail);
	assign ram_waddr = clr_done ? c_slot_q : clr_cnt_q[SLOT_W-1:0];
	assign ram_wdata = clr_done ? res_c : '0;

	sfmu_ram #(
		.WIDTH(RAM_W),
		.DEPTH(MODE_SLOTS)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (adv_up),
		.raddr(sb_q[LANE_LAT-1].slot),
		.rdata(ram_rdata)
	);

	// Most recent write, forwarded over the memory read that missed it.
	logic              lw_valid_q;
	logic [SLOT_W-1:0] lw_slot_q;
	logic [RAM_W-1:0]  lw_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			lw_valid_q <= 1'b0;
		else if (clr_done && c_valid_q && adv_tail)
			lw_valid_q <= 1'b1;
	end

	always_ff @(posedge clk) begin
		if (clr_done && c_valid_q && adv_tail) begin
			lw_slot_q <= c_slot_q;
			lw_data_q <= res_c;
		end
	end

	// Stage B: old spectrum in hand, drift and diffusion products.
	logic                  b_zero_q;
	logic signed [P_W-1:0] b_p_q [NLANE];
	logic [RAM_W-1:0]      s_b;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			b_valid_q <= 1'b0;
		else if (adv_tail)
			b_valid_q <= adv_up && sb_q[LANE_LAT-1].valid;
	end

	always_ff @(posedge clk) begin
		if (adv_up) begin
			b_slot_q <= sb_q[LANE_LAT-1].slot;
			b_zero_q <= sb_q[LANE_LAT-1].zero;
			for (int i = 0; i < NLANE; i++)
				b_p_q[i] <= p_a[i];
		end
	end

	assign s_b = (lw_valid_q && (lw_slot_q == b_slot_q)) ? lw_data_q : ram_rdata;

	// Stage C: rounded blend, saturation and write-back.
	logic                       c_zero_q;
	logic signed [MX_W-1:0]     c_mx_q [NLANE];
	logic signed [MY_W-1:0]     c_my_q [NLANE];
	logic [RAM_W-1:0]           c_s_q;
	logic signed [SUM_W-1:0]    sum_c [NLANE];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			c_valid_q <= 1'b0;
		else if (adv_tail)
			c_valid_q <= b_valid_q;
	end

	always_ff @(posedge clk) begin
		if (adv_tail) begin
			c_slot_q <= b_slot_q;
			c_zero_q <= b_zero_q;
			c_s_q    <= s_b;
			for (int i = 0; i < NLANE; i++) begin
				c_mx_q[i] <= $signed({1'b0, drift_eff[i % NDIM]})
				           * $signed(s_b[i*SAMPLE_W +: SAMPLE_W]);
				c_my_q[i] <= $signed({1'b0, diff_use[i % NDIM]}) * b_p_q[i];
			end
		end
	end

	always_comb begin
		for (int i = 0; i < NLANE; i++) begin
			sum_c[i] = SUM_W'(c_mx_q[i]) + SUM_W'(c_my_q[i]) + SUM_W'(32768);
			res_c[i*SAMPLE_W +: SAMPLE_W] = c_zero_q ? c_s_q[i*SAMPLE_W +: SAMPLE_W]
			                              : sat_sample(sum_c[i][SUM_W-1:16]);
		end
	end

	// Stage D: output register.
	logic [SLOT_W-1:0] d_slot_q;
	logic              d_zero_q;
	logic [RAM_W-1:0]  d_spec_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			d_valid_q <= 1'b0;
		else if (adv_tail)
			d_valid_q <= c_valid_q;
	end

	always_ff @(posedge clk) begin
		if (adv_tail && c_valid_q) begin
			d_slot_q <= c_slot_q;
			d_zero_q <= c_zero_q;
			d_spec_q <= res_c;
		end
	end

	assign m_axis_tvalid = d_valid_q;
	assign m_axis_tdata  = {{(160 - SLOT_W - RAM_W){1'b0}}, d_spec_q, d_slot_q};
	assign m_axis_tuser  = d_zero_q;

	// Checks on the read-modify-write window and the clearing pass.
	a_no_rmw_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		b_valid_q && c_valid_q |-> b_slot_q != c_slot_q)
		else $error("same slot in read and write stage");

	a_clear_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		!clr_done |-> !s_axis_tready && !c_valid_q)
		else $error("traffic during clearing pass");

	a_hazard_bubble: assert property (@(posedge clk) disable iff (!arst_n)
		hazard && adv_tail |=> !b_valid_q)
		else $error("hazard did not insert a bubble");

endmodule

// ----- hdl/sfmu_ram.sv -----
// Generic single-write, single-read memory with a registered read port.
// No dependencies; read during a write to the same address returns the old data.

module sfmu_ram #(
	parameter int WIDTH = 144,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Storage array and read register.
	always_ff @(posedge clk) begin
		if (we)
			mem_q[waddr] <= wdata;
		if (re)
			rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ----- hdl/sfmu_div.sv -----
// Pipelined restoring divider, one quotient bit per stage.
// No dependencies; the caller guarantees that the quotient fits in Q_W bits.

module sfmu_div #(
	parameter int DVD_W = 35,
	parameter int DIV_W = 10,
	parameter int Q_W   = 26
) (
	input  logic             clk,
	input  logic             en,
	input  logic [DVD_W-1:0] dividend,
	input  logic [DIV_W-1:0] divisor,
	output logic [Q_W-1:0]   quotient
);

	logic [DIV_W-1:0] rem_q [Q_W];
	logic [Q_W-1:0]   lo_q  [Q_W];
	logic [Q_W-1:0]   quo_q [Q_W];
	logic [DIV_W-1:0] d_q   [Q_W];

	logic [DIV_W-1:0] rem_in [Q_W];
	logic [Q_W-1:0]   lo_in  [Q_W];
	logic [Q_W-1:0]   quo_in [Q_W];
	logic [DIV_W-1:0] d_in   [Q_W];
	logic [DIV_W:0]   trial  [Q_W];
	logic             take   [Q_W];

	// Each stage shifts in the next dividend bit and tries one subtraction.
	always_comb begin
		for (int i = 0; i < Q_W; i++) begin
			if (i == 0) begin
				rem_in[i] = DIV_W'(dividend[DVD_W-1:Q_W]);
				lo_in[i]  = dividend[Q_W-1:0];
				quo_in[i] = '0;
				d_in[i]   = divisor;
			end else begin
				rem_in[i] = rem_q[i-1];
				lo_in[i]  = lo_q[i-1];
				quo_in[i] = quo_q[i-1];
				d_in[i]   = d_q[i-1];
			end
			trial[i] = {rem_in[i], lo_in[i][Q_W-1]};
			take[i]  = (trial[i] >= {1'b0, d_in[i]});
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < Q_W; i++) begin
				rem_q[i] <= take[i] ? DIV_W'(trial[i] - {1'b0, d_in[i]}) : trial[i][DIV_W-1:0];
				quo_q[i] <= {quo_in[i][Q_W-2:0], take[i]};
				lo_q[i]  <= {lo_in[i][Q_W-2:0], 1'b0};
				d_q[i]   <= d_in[i];
			end
		end
	end

	assign quotient = quo_q[Q_W-1];

endmodule

// ----- hdl/sfmu_proj.sv -----
// One projection lane: p = floor((a*w*k2 + kw*dot + k2/2 * 2^16) / (k2 * 2^16)).
// Depends on sfmu_pkg and sfmu_div.

module sfmu_proj import sfmu_pkg::*; (
	input  logic                       clk,
	input  logic                       en,
	input  logic signed [SAMPLE_W-1:0] a,
	input  logic        [COEF_W-1:0]   w,
	input  logic        [K2_W-1:0]     k2,
	input  logic signed [KW_W-1:0]     kw,
	input  logic signed [DOT_W-1:0]    dot,
	output logic signed [P_W-1:0]      p
);

	localparam int AK_W  = SAMPLE_W + K2_W + 1;
	localparam int T1_W  = AK_W + COEF_W + 1;
	localparam int NUM_W = KW_W + DOT_W;

	logic signed [AK_W-1:0]  ak_l1;
	logic signed [NUM_W-1:0] t2_l1;
	logic        [K2_W-1:0]  k2_l1;
	logic signed [T1_W-1:0]  t1_l2;
	logic signed [NUM_W-1:0] t2_l2;
	logic        [K2_W-1:0]  k2_l2;
	logic        [DVD_W-1:0] mag_l3;
	logic        [K2_W-1:0]  k2_l3;
	logic                    neg_l3;
	logic                    neg_q [Q_W];

	logic signed [NUM_W-1:0] num;
	logic signed [NUM_W-17:0] n1;
	logic [Q_W-1:0]          quo;

	// Numerator terms, then their sum scaled down by 2^16.
	assign num = NUM_W'(t1_l2) + t2_l2 + $signed(NUM_W'({k2_l2, 15'b0}));
	assign n1  = num[NUM_W-1:16];

	always_ff @(posedge clk) begin
		if (en) begin
			ak_l1  <= a * $signed({1'b0, k2});
			t2_l1  <= NUM_W'(kw) * NUM_W'(dot);
			k2_l1  <= k2;
			t1_l2  <= ak_l1 * $signed({1'b0, w});
			t2_l2  <= t2_l1;
			k2_l2  <= k2_l1;
			// Floor division of a negative value goes through its complement.
			neg_l3 <= n1[NUM_W-17];
			mag_l3 <= n1[NUM_W-17] ? DVD_W'(~n1) : DVD_W'(n1);
			k2_l3  <= k2_l2;
			neg_q[0] <= neg_l3;
			for (int i = 1; i < Q_W; i++)
				neg_q[i] <= neg_q[i-1];
		end
	end

	sfmu_div #(
		.DVD_W(DVD_W),
		.DIV_W(K2_W),
		.Q_W  (Q_W)
	) u_div (
		.clk     (clk),
		.en      (en),
		.dividend(mag_l3),
		.divisor (k2_l3),
		.quotient(quo)
	);

	assign p = neg_q[Q_W-1] ? ~$signed({1'b0, quo}) : $signed({1'b0, quo});

endmodule

// ----- bench/tb_spectral_forcing_mode_update.sv -----
`timescale 1ns / 100ps
// Self-checking bench for spectral_forcing_mode_update: stream driver, stream monitor and
// APB register writes, with an in-bench model of the mode table. Depends on sfmu_pkg.

module tb_spectral_forcing_mode_update;
	import sfmu_pkg::*;

	localparam int  SETTLE_CYCLES = 50;
	localparam int  STALL_LIMIT   = 5000;
	localparam int  HOLDOFF_LEN   = 400;
	localparam int  SEG_ITEMS     = 125;
	localparam longint Q16        = 65536;

	typedef struct {
		logic [SLOT_W-1:0]          slot;
		logic signed [WAVE_W-1:0]   wave [NDIM];
		logic signed [SAMPLE_W-1:0] inj [2][NDIM];
	} mode_item_t;

	typedef struct {
		logic [SLOT_W-1:0]          slot;
		logic signed [SAMPLE_W-1:0] spec [2][NDIM];
		logic                       zero;
	} mode_result_t;

	logic         clk;
	logic         arst_n;
	logic         psel;
	logic         penable;
	logic         pwrite;
	logic [4:0]   paddr;
	logic [31:0]  pwdata;
	logic [31:0]  prdata;
	logic         pready;
	logic         s_axis_tvalid;
	logic         s_axis_tready;
	logic [175:0] s_axis_tdata;
	logic         m_axis_tvalid;
	logic         m_axis_tready;
	logic [159:0] m_axis_tdata;
	logic [0:0]   m_axis_tuser;

	mode_item_t   pending_modes [$];
	mode_result_t expected_spectra [$];
	mode_item_t   offered_mode;
	longint       spec_table [2][NDIM][MODE_SLOTS];
	int unsigned  cfg_regs [8];
	int           send_idle_pct;
	int           recv_idle_pct;
	int           err_count;
	int           quiet_cycles;
	int           holdoff_left;
	logic         holdoff_go;

	spectral_forcing_mode_update i_dut (.*);

	// Clock.
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	task automatic report_mismatch(input string field, input longint got, input longint want);
		$display("mismatch %s: got %0d expected %0d at %0t", field, got, want, $realtime);
		err_count++;
	endtask

	function automatic longint coef_q16(input int unsigned r);
		return (r > Q16) ? Q16 : longint'(r);
	endfunction

	function automatic longint sat_q420(input longint v);
		longint hi;
		hi = (longint'(1) << (SAMPLE_W - 1)) - 1;
		return (v > hi) ? hi : ((v < -hi - 1) ? -hi - 1 : v);
	endfunction

	function automatic void split_q16(input longint n, output longint q, output longint r);
		q = n / Q16;
		r = n % Q16;
		if (r < 0) begin
			r += Q16;
			q -= 1;
		end
	endfunction

	// Round (drift*s + diffusion*p) / 2^16 with ties up, then saturate.
	function automatic longint ou_blend(input longint d, input longint s, input longint f,
			input longint p);
		longint qx, rx, qy, ry;
		split_q16(d * s, qx, rx);
		split_q16(f * p, qy, ry);
		return sat_q420(qx + qy + (rx + ry + Q16 / 2) / Q16);
	endfunction

	// Project the injection, step the stored spectrum and return the new one.
	function automatic mode_result_t update_mode(input mode_item_t it);
		mode_result_t res;
		longint k [NDIM];
		longint a [2][NDIM];
		longint dft [NDIM];
		longint dif [NDIM];
		longint w, k2, den, dot, num, p, q;
		int idx;
		w = coef_q16(cfg_regs[REG_WEIGHT]);
		idx = int'(it.slot);
		for (int c = 0; c < NDIM; c++) begin
			k[c] = longint'(it.wave[c]);
			if (k[c] > MAX_WAVE) k[c] = MAX_WAVE;
			if (k[c] < -MAX_WAVE) k[c] = -MAX_WAVE;
			a[0][c] = longint'(it.inj[0][c]);
			a[1][c] = longint'(it.inj[1][c]);
			dft[c] = coef_q16(cfg_regs[int'(REG_DRIFT_X) + c]);
			dif[c] = coef_q16(cfg_regs[int'(REG_DIFF_X) + c]);
		end
		res.zero = (k[0] == 0 && k[1] == 0 && k[2] == 0);
		if (!res.zero) begin
			k2 = k[0] * k[0] + k[1] * k[1] + k[2] * k[2];
			den = k2 * Q16;
			for (int part = 0; part < 2; part++) begin
				dot = k[0] * a[part][0] + k[1] * a[part][1] + k[2] * a[part][2];
				for (int c = 0; c < NDIM; c++) begin
					if (cfg_regs[REG_DECAY] != 0) begin
						spec_table[part][c][idx] = ou_blend(dft[c], spec_table[part][c][idx], 0, 0);
					end else begin
						num = a[part][c] * w * k2 + k[c] * (Q16 - 2 * w) * dot + den / 2;
						q = num / den;
						if (num % den < 0) q -= 1;
						p = q;
						spec_table[part][c][idx] = ou_blend(dft[c], spec_table[part][c][idx],
							dif[c], p);
					end
				end
			end
		end
		res.slot = it.slot;
		for (int part = 0; part < 2; part++)
			for (int c = 0; c < NDIM; c++)
				res.spec[part][c] = spec_table[part][c][idx][SAMPLE_W-1:0];
		return res;
	endfunction

	function automatic logic [175:0] pack_mode(input mode_item_t it);
		logic [175:0] d;
		d = '0;
		d[SLOT_W-1:0] = it.slot;
		for (int c = 0; c < NDIM; c++) begin
			d[SLOT_W + WAVE_W*c +: WAVE_W] = it.wave[c];
			d[28 + SAMPLE_W*c +: SAMPLE_W] = it.inj[0][c];
			d[100 + SAMPLE_W*c +: SAMPLE_W] = it.inj[1][c];
		end
		return d;
	endfunction

	// Stream driver: predicts each accepted transaction, then offers the next item.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata  <= '0;
		end else begin
			if (s_axis_tvalid && s_axis_tready)
				expected_spectra.push_back(update_mode(offered_mode));
			if (!s_axis_tvalid || s_axis_tready) begin
				if (pending_modes.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
					offered_mode = pending_modes.pop_front();
					s_axis_tvalid <= 1'b1;
					s_axis_tdata  <= pack_mode(offered_mode);
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	// Long receiver hold-off, counted here.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			holdoff_left <= 0;
		else if (holdoff_go)
			holdoff_left <= HOLDOFF_LEN;
		else if (holdoff_left > 0)
			holdoff_left <= holdoff_left - 1;
	end

	// Stream monitor: compares each result transaction with the oldest expectation.
	always @(posedge clk or negedge arst_n) begin
		mode_result_t want;
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				if (expected_spectra.size() == 0) begin
					report_mismatch("unexpected result", 1, 0);
				end else begin
					want = expected_spectra.pop_front();
					if (m_axis_tdata[SLOT_W-1:0] !== want.slot)
						report_mismatch("out_slot", m_axis_tdata[SLOT_W-1:0], want.slot);
					for (int part = 0; part < 2; part++)
						for (int c = 0; c < NDIM; c++)
							if (m_axis_tdata[SLOT_W + SAMPLE_W*(NDIM*part + c) +: SAMPLE_W]
									!== want.spec[part][c])
								report_mismatch($sformatf("spectrum part %0d dim %0d", part, c),
									$signed(m_axis_tdata[SLOT_W + SAMPLE_W*(NDIM*part + c)
										+: SAMPLE_W]), want.spec[part][c]);
					if (m_axis_tuser[0] !== want.zero)
						report_mismatch("zero_wave", m_axis_tuser[0], want.zero);
				end
			end
			m_axis_tready <= (holdoff_left == 0) && ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// Watchdog on cycles without any transaction.
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input int unsigned value);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		cfg_regs[idx] = (idx == REG_DECAY) ? (value & 1) : (value & 32'h1FFFF);
	endtask

	// Wait until the block has drained, then a little longer.
	task automatic drain_block();
		while (pending_modes.size() > 0 || s_axis_tvalid || expected_spectra.size() > 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	function automatic int unsigned pick_coef();
		case ($urandom_range(5))
			0: return 0;
			1: return 65536;
			2: return $urandom_range(131071, 65537);
			default: return $urandom_range(65536, 0);
		endcase
	endfunction

	task automatic random_config(input bit decay);
		write_reg(REG_DRIFT_X, pick_coef());
		write_reg(REG_DRIFT_Y, pick_coef());
		write_reg(REG_DRIFT_Z, pick_coef());
		write_reg(REG_DIFF_X, pick_coef());
		write_reg(REG_DIFF_Y, pick_coef());
		write_reg(REG_DIFF_Z, pick_coef());
		write_reg(REG_WEIGHT, pick_coef());
		write_reg(REG_DECAY, decay);
	endtask

	function automatic mode_item_t fixed_mode(input int slot, input int kx, input int ky,
			input int kz, input int ae, input int ao);
		mode_item_t it;
		it.slot = slot;
		it.wave[0] = kx;
		it.wave[1] = ky;
		it.wave[2] = kz;
		for (int c = 0; c < NDIM; c++) begin
			it.inj[0][c] = ae + c * 4099;
			it.inj[1][c] = ao - c * 7001;
		end
		return it;
	endfunction

	// Random mode; slots mostly from a small set so that the table state builds up.
	function automatic mode_item_t random_mode();
		mode_item_t it;
		it.slot = ($urandom_range(3) == 0) ? $urandom_range(1023) : $urandom_range(15);
		for (int c = 0; c < NDIM; c++) begin
			case ($urandom_range(9))
				0: it.wave[c] = $urandom;
				1: it.wave[c] = 0;
				default: it.wave[c] = $urandom_range(32) - 16;
			endcase
			for (int part = 0; part < 2; part++)
				case ($urandom_range(7))
					0: it.inj[part][c] = {1'b0, {(SAMPLE_W-1){1'b1}}};
					1: it.inj[part][c] = {1'b1, {(SAMPLE_W-1){1'b0}}};
					default: it.inj[part][c] = $urandom;
				endcase
		end
		if ($urandom_range(11) == 0) begin
			it.wave[0] = 0;
			it.wave[1] = 0;
			it.wave[2] = 0;
		end
		return it;
	endfunction

	// Stimulus sequence.
	initial begin
		err_count     = 0;
		send_idle_pct = 30;
		recv_idle_pct = 57;
		holdoff_go    = 1'b0;
		quiet_cycles  = 0;
		psel          = 1'b0;
		penable       = 1'b0;
		pwrite        = 1'b0;
		paddr         = '0;
		pwdata        = '0;
		foreach (spec_table[p, c, s]) spec_table[p][c][s] = 0;
		cfg_regs = '{65536, 65536, 65536, 0, 0, 0, 65536, 0};
		arst_n = 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: field extremes, clamped waves, repeated slots, zero wave vector.
		write_reg(REG_DRIFT_X, 60000);
		write_reg(REG_DRIFT_Y, 131071);
		write_reg(REG_DRIFT_Z, 0);
		write_reg(REG_DIFF_X, 30000);
		write_reg(REG_DIFF_Y, 65536);
		write_reg(REG_DIFF_Z, 100000);
		write_reg(REG_WEIGHT, 32768);
		pending_modes.push_back(fixed_mode(0, 1, 0, 0, 8388607, 8388607));
		pending_modes.push_back(fixed_mode(1023, -16, 16, -16, -8388608, -8388608));
		pending_modes.push_back(fixed_mode(1023, 31, -32, 0, -8388608, 8388607));
		pending_modes.push_back(fixed_mode(0, 0, 0, 3, 1234567, -7654321));
		pending_modes.push_back(fixed_mode(0, 0, 0, 0, 999, -999));
		pending_modes.push_back(fixed_mode(5, 16, 16, 16, 8388607, -8388608));
		pending_modes.push_back(fixed_mode(5, -1, 2, -3, 0, 0));
		drain_block();

		// Decay mode, including a zero wave vector.
		write_reg(REG_DECAY, 1);
		pending_modes.push_back(fixed_mode(0, 2, 0, 0, 8388607, 8388607));
		pending_modes.push_back(fixed_mode(1023, 0, 0, 0, 1, 1));
		pending_modes.push_back(fixed_mode(1023, 5, -5, 1, -8388608, 8388607));
		drain_block();

		// Purely compressive and clamped-to-solenoidal projections.
		write_reg(REG_DECAY, 0);
		write_reg(REG_WEIGHT, 0);
		pending_modes.push_back(fixed_mode(7, 3, -4, 12, 4000000, -4000000));
		pending_modes.push_back(fixed_mode(7, -16, 1, 0, -8388608, 8388607));
		drain_block();
		write_reg(REG_WEIGHT, 131071);
		pending_modes.push_back(fixed_mode(7, 3, -4, 12, 4000000, -4000000));
		pending_modes.push_back(fixed_mode(8, 1, 1, 1, 8388607, -8388608));
		drain_block();

		// Random segments, each under its own settings.
		for (int seg = 0; seg < 6; seg++) begin
			if (seg == 2) begin
				send_idle_pct <= 57;
				recv_idle_pct <= 30;
			end else if (seg == 4) begin
				send_idle_pct <= 0;
				recv_idle_pct <= 0;
			end
			random_config(seg == 3);
			if (seg == 4) begin
				@(posedge clk);
				holdoff_go <= 1'b1;
				@(posedge clk);
				holdoff_go <= 1'b0;
			end
			for (int n = 0; n < SEG_ITEMS; n++)
				pending_modes.push_back(random_mode());
			drain_block();
		end

		if (err_count == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
